### rtl/core/idbm_pkg.sv
`default_nettype none

package idbm_pkg;

  localparam int DEF_NUM_IDS = 64;
  localparam int WORD_BITS   = 32;
  localparam int WORD_SHIFT  = 5;
  localparam int ID_W        = 6;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_NONE_FREE   = 2'd1,
    STAT_DOUBLE_FREE = 2'd2,
    STAT_RESERVED    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_OUT
  } state_t;

  function automatic int map_words(input int num_ids);
    return (num_ids + WORD_BITS - 1) / WORD_BITS;
  endfunction

  function automatic int addr_bits(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

`default_nettype wire

### rtl/core/idbm_ram.sv
`default_nettype none

module idbm_ram #(
  parameter int WIDTH = idbm_pkg::WORD_BITS,
  parameter int DEPTH = 2,
  localparam int AW   = idbm_pkg::addr_bits(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/idbm_ffz.sv
`default_nettype none

// lowest free, in-range, nonzero id bit of one map word, at or above lo when use_lo is set
module idbm_ffz #(
  parameter int NUM_IDS = idbm_pkg::DEF_NUM_IDS,
  localparam int WAW    = idbm_pkg::addr_bits(idbm_pkg::map_words(NUM_IDS))
) (
  input  wire logic [idbm_pkg::WORD_BITS-1:0]  word,
  input  wire logic [WAW-1:0]                  widx,
  input  wire logic [idbm_pkg::WORD_SHIFT-1:0] lo,
  input  wire logic                            use_lo,
  output logic                                 hit,
  output logic [idbm_pkg::WORD_SHIFT-1:0]      pos
);

  logic [idbm_pkg::WORD_BITS-1:0] avail;

  always_comb begin
    for (int b = 0; b < idbm_pkg::WORD_BITS; b++) begin
      avail[b] = !word[b]
                 && (int'({widx, idbm_pkg::WORD_SHIFT'(b)}) < NUM_IDS)
                 && !(widx == '0 && b == 0)
                 && (!use_lo || idbm_pkg::WORD_SHIFT'(b) >= lo);
    end
  end

  always_comb begin
    hit = 1'b0;
    pos = '0;
    for (int b = idbm_pkg::WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        hit = 1'b1;
        pos = idbm_pkg::WORD_SHIFT'(b);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/id_bitmap_next_fit_allocator.sv
// Next-fit identifier allocator. Each transfer on s_ is one request: allocate
// (returns the first free id at or above the search hint, wrapping to 1, and
// advances the hint) or free (releases an id in use and lowers the hint to
// it if it lies below the hint). Each request gives exactly one transfer on m_
// with a status and the granted id; id 0 is reserved. The used map sits in a
// RAM of 32-bit words with one write and one read port, both addressed by the
// word index, and is scanned by one find-first-free encoder, one word at a
// time (read, then check). An allocate examines 1 to ceil(NUM_IDS/32) + 1
// words; a free reads and checks its id's word, and a free of id 0 or an
// out-of-range id goes straight to the result. One request is in work at a time; the result
// register lets the next request be accepted while a result waits. The map
// needs no clearing pass after reset: words never written read as free.
`default_nettype none

module id_bitmap_next_fit_allocator #(
  parameter int NUM_IDS = idbm_pkg::DEF_NUM_IDS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [idbm_pkg::IN_TDATA_W-1:0]     s_tdata,  // operation, id_value, pad
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [idbm_pkg::OUT_TDATA_W-1:0]    m_tdata   // status, id_out
);

  localparam int WORDS = idbm_pkg::map_words(NUM_IDS);
  localparam int WAW   = idbm_pkg::addr_bits(WORDS);
  localparam int IW    = $clog2(NUM_IDS);
  localparam int WB    = idbm_pkg::WORD_BITS;
  localparam int WS    = idbm_pkg::WORD_SHIFT;

  idbm_pkg::state_t  state, state_next;
  logic [WAW-1:0]    widx, widx_next;
  logic              pass2, pass2_next;
  logic [IW-1:0]     hint, hint_next;
  idbm_pkg::op_t     op_q, op_next;
  logic [idbm_pkg::ID_W-1:0] id_q, id_next;
  idbm_pkg::status_t res_status, res_status_next;
  logic [idbm_pkg::ID_W-1:0] res_id, res_id_next;
  logic [WORDS-1:0]  wvalid;

  logic              ram_we, ram_re;
  logic [WB-1:0]     ram_wdata, ram_rdata, word_eff;
  logic              ffz_hit, ffz_use_lo;
  logic [WS-1:0]     ffz_pos;
  logic [WAW-1:0]    hint_word;
  logic [IW-1:0]     found_id, id_ext;
  logic              out_load;
  logic [WS-1:0]     id_bit;

  assign s_tready  = (state == idbm_pkg::S_IDLE);
  assign hint_word = WAW'(hint >> WS);
  assign word_eff  = wvalid[widx] ? ram_rdata : '0;
  assign ffz_use_lo = !pass2 && (widx == hint_word);
  assign found_id  = IW'({widx, ffz_pos});
  assign id_ext    = IW'(id_q);
  assign id_bit    = id_q[WS-1:0];
  assign ram_re    = (state == idbm_pkg::S_RD);
  assign out_load  = (state == idbm_pkg::S_OUT) && (!m_tvalid || m_tready);

  idbm_ram #(
    .WIDTH (WB),
    .DEPTH (WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (widx),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (widx),
    .rdata (ram_rdata)
  );

  idbm_ffz #(
    .NUM_IDS (NUM_IDS)
  ) u_ffz (
    .word   (word_eff),
    .widx   (widx),
    .lo     (hint[WS-1:0]),
    .use_lo (ffz_use_lo),
    .hit    (ffz_hit),
    .pos    (ffz_pos)
  );

  always_comb begin
    state_next      = state;
    widx_next       = widx;
    pass2_next      = pass2;
    hint_next       = hint;
    op_next         = op_q;
    id_next         = id_q;
    res_status_next = res_status;
    res_id_next     = res_id;
    ram_we          = 1'b0;
    ram_wdata       = word_eff;
    unique case (state)
      idbm_pkg::S_IDLE: begin
        if (s_tvalid) begin
          op_next         = idbm_pkg::op_t'(s_tdata[0]);
          id_next         = s_tdata[idbm_pkg::ID_W:1];
          res_id_next     = '0;
          res_status_next = idbm_pkg::STAT_OK;
          pass2_next      = 1'b0;
          if (idbm_pkg::op_t'(s_tdata[0]) == idbm_pkg::OP_ALLOC) begin
            widx_next  = hint_word;
            state_next = idbm_pkg::S_RD;
          end else if (s_tdata[idbm_pkg::ID_W:1] == '0) begin
            res_status_next = idbm_pkg::STAT_RESERVED;
            state_next      = idbm_pkg::S_OUT;
          end else if (int'(s_tdata[idbm_pkg::ID_W:1]) >= NUM_IDS) begin
            res_status_next = idbm_pkg::STAT_DOUBLE_FREE;
            state_next      = idbm_pkg::S_OUT;
          end else begin
            widx_next  = WAW'(s_tdata[idbm_pkg::ID_W:1] >> WS);
            state_next = idbm_pkg::S_RD;
          end
        end
      end
      idbm_pkg::S_RD: begin
        state_next = idbm_pkg::S_CHK;
      end
      idbm_pkg::S_CHK: begin
        if (op_q == idbm_pkg::OP_FREE) begin
          if (!word_eff[id_bit]) begin
            res_status_next = idbm_pkg::STAT_DOUBLE_FREE;
          end else begin
            ram_we            = 1'b1;
            ram_wdata[id_bit] = 1'b0;
            if (id_ext < hint) begin
              hint_next = id_ext;
            end
          end
          state_next = idbm_pkg::S_OUT;
        end else if (ffz_hit) begin
          ram_we             = 1'b1;
          ram_wdata[ffz_pos] = 1'b1;
          res_id_next        = idbm_pkg::ID_W'(found_id);
          if (int'(found_id) + 1 < NUM_IDS) begin
            hint_next = found_id + IW'(1);
          end else begin
            hint_next = IW'(1);
          end
          state_next = idbm_pkg::S_OUT;
        end else if (!pass2) begin
          if (widx == WAW'(WORDS - 1)) begin
            pass2_next = 1'b1;
            widx_next  = '0;
          end else begin
            widx_next = widx + WAW'(1);
          end
          state_next = idbm_pkg::S_RD;
        end else if (widx == hint_word) begin
          res_status_next = idbm_pkg::STAT_NONE_FREE;
          state_next      = idbm_pkg::S_OUT;
        end else begin
          widx_next  = widx + WAW'(1);
          state_next = idbm_pkg::S_RD;
        end
      end
      idbm_pkg::S_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = idbm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = idbm_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= idbm_pkg::S_IDLE;
      hint     <= IW'(1);
      wvalid   <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      hint  <= hint_next;
      if (ram_we) begin
        wvalid[widx] <= 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    widx       <= widx_next;
    pass2      <= pass2_next;
    op_q       <= op_next;
    id_q       <= id_next;
    res_status <= res_status_next;
    res_id     <= res_id_next;
    if (out_load) begin
      m_tdata <= {res_id, res_status};
    end
  end

endmodule

`default_nettype wire

### rtl/core/idbm_checker.sv
`default_nettype none

module idbm_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  input wire logic [idbm_pkg::IN_TDATA_W-1:0]  s_tdata,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [idbm_pkg::OUT_TDATA_W-1:0] m_tdata
);

  logic [1:0] pending;
  logic       in_xfer, out_xfer;

  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_xfer && !out_xfer) begin
      pending <= pending + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pending <= pending - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_fail_no_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != idbm_pkg::STAT_OK) |-> (m_tdata[7:2] == '0))
    else $error("id given with a failing status");

  a_result_has_request: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pending != 2'd0) && (pending != 2'd3))
    else $error("result without matching request");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (s_tdata[0] == idbm_pkg::OP_ALLOC) |=> !s_tready)
    else $error("new request taken while a scan runs");

endmodule

bind id_bitmap_next_fit_allocator idbm_checker u_idbm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
